/* hdl/wtob_pkg.sv */
// Shared types and constants of the wavetable oscillator bank.
// Used by the controller, the datapath and the top level; no dependencies.
package wtob_pkg;

  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  // Quarter-wave magnitude table holds entries 0 through 2048.
  localparam logic [11:0] QROM_LAST  = 12'd2048;

  localparam logic [2:0] CFG_AMP_THRESHOLD   = 3'd0;
  localparam logic [2:0] CFG_FREQ_SCALE      = 3'd1;
  localparam logic [2:0] CFG_ACTIVE_CHANNELS = 3'd2;
  localparam logic [2:0] CFG_HOP_LENGTH      = 3'd3;
  localparam logic [2:0] CFG_TABLE_GAIN      = 3'd4;

  typedef struct packed {
    logic [15:0] amp_threshold;
    logic [31:0] freq_scale;
    logic [9:0]  active_channels;
    logic [12:0] hop_length;
    logic [12:0] table_gain;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        phase;
    logic [31:0]        amp_now;
    logic signed [32:0] amp_step;
    logic signed [31:0] freq_now;
    logic signed [32:0] freq_step;
    logic [15:0]        amp_target;
    logic signed [31:0] freq_target;
    logic [12:0]        ramp_left;
    logic               active;
  } chan_rec_t;

  typedef struct packed {
    logic take;
    logic tk_start;
    logic clr_step;
    logic rom_x;
    logic rom_x2;
    logic rom_mul;
    logic rom_div_start;
    logic rom_div_take;
    logic rom_fin;
    logic ld_read;
    logic ld_eval;
    logic ld_da_take;
    logic ld_df_take;
    logic tk_issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rom_last;
    logic k_last;
    logic div_done;
    logic ld_skip;
    logic ld_silent;
    logic chan_last;
    logic pipe_empty;
  } stat_t;

  // Taylor divisor (2k-1)*2k for term k of the cosine series.
  function automatic logic [12:0] taylor_div(input logic [2:0] k);
    logic [12:0] r;
    unique case (k)
      3'd1:    r = 13'd2;
      3'd2:    r = 13'd12;
      3'd3:    r = 13'd30;
      3'd4:    r = 13'd56;
      3'd5:    r = 13'd90;
      3'd6:    r = 13'd132;
      3'd7:    r = 13'd182;
      default: r = 13'd1;
    endcase
    return r;
  endfunction

endpackage

/* hdl/wtob_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned 33 by 13 bits.
// Standalone; used by the oscillator bank datapath.
module wtob_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [12:0] divisor,
  output logic        done,
  output logic [32:0] quotient
);

  localparam int STEPS = 33;

  logic [5:0]  cnt;
  logic        busy;
  logic [12:0] rem;
  logic [32:0] quo;
  logic [12:0] dq;
  logic [13:0] sh;
  logic [14:0] diff;

  assign sh       = {rem, quo[32]};
  assign diff     = {1'b0, sh} - {2'b00, dq};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(STEPS);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dq  <= divisor;
    end else if (busy) begin
      if (!diff[14]) begin
        rem <= diff[12:0];
        quo <= {quo[31:0], 1'b1};
      end else begin
        rem <= sh[12:0];
        quo <= {quo[31:0], 1'b0};
      end
    end
  end

endmodule

/* hdl/wtob_ctrl.sv */
// Sequencing state machine of the oscillator bank.
// Depends on wtob_pkg for the command and status structs.
module wtob_ctrl import wtob_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_mode,
  input  logic  out_free,
  input  stat_t stat,
  output logic  in_ready,
  output cmd_t  cmd
);

  typedef enum logic [14:0] {
    S_CLR    = 15'h0001,
    S_RX     = 15'h0002,
    S_RX2    = 15'h0004,
    S_RMUL   = 15'h0008,
    S_RDIV   = 15'h0010,
    S_RWAIT  = 15'h0020,
    S_RFIN   = 15'h0040,
    S_IDLE   = 15'h0080,
    S_LRD    = 15'h0100,
    S_LEVAL  = 15'h0200,
    S_LDA    = 15'h0400,
    S_LDF    = 15'h0800,
    S_TRUN   = 15'h1000,
    S_TDRAIN = 15'h2000,
    S_TOUT   = 15'h4000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_RX;
      end
      S_RX: begin
        cmd.rom_x  = 1'b1;
        state_next = S_RX2;
      end
      S_RX2: begin
        cmd.rom_x2 = 1'b1;
        state_next = S_RMUL;
      end
      S_RMUL: begin
        cmd.rom_mul = 1'b1;
        state_next  = S_RDIV;
      end
      S_RDIV: begin
        cmd.rom_div_start = 1'b1;
        state_next        = S_RWAIT;
      end
      S_RWAIT: begin
        if (stat.div_done) begin
          cmd.rom_div_take = 1'b1;
          state_next       = stat.k_last ? S_RFIN : S_RMUL;
        end
      end
      S_RFIN: begin
        cmd.rom_fin = 1'b1;
        state_next  = stat.rom_last ? S_IDLE : S_RX;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_mode) begin
            cmd.tk_start = 1'b1;
            state_next   = S_TRUN;
          end else begin
            state_next = S_LRD;
          end
        end
      end
      S_LRD: begin
        if (stat.ld_skip) begin
          state_next = S_IDLE;
        end else begin
          cmd.ld_read = 1'b1;
          state_next  = S_LEVAL;
        end
      end
      S_LEVAL: begin
        cmd.ld_eval = 1'b1;
        state_next  = stat.ld_silent ? S_IDLE : S_LDA;
      end
      S_LDA: begin
        if (stat.div_done) begin
          cmd.ld_da_take = 1'b1;
          state_next     = S_LDF;
        end
      end
      S_LDF: begin
        if (stat.div_done) begin
          cmd.ld_df_take = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_TRUN: begin
        cmd.tk_issue = 1'b1;
        if (stat.chan_last) state_next = S_TDRAIN;
      end
      S_TDRAIN: begin
        if (stat.pipe_empty) state_next = S_TOUT;
      end
      S_TOUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

endmodule

/* hdl/wtob_dp.sv */
// Datapath of the oscillator bank: channel memory, cosine table, tick pipeline,
// load arithmetic. Depends on wtob_pkg and wtob_div.
module wtob_dp import wtob_pkg::*; #(
  parameter int CHANNELS = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  cfg_t        cfg,
  input  logic [8:0]  in_channel,
  input  logic [15:0] in_amplitude,
  input  logic [23:0] in_frequency,
  output stat_t       stat,
  output logic [31:0] sample
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

  chan_rec_t   cmem [CHANNELS];
  logic [14:0] qrom [0:2048];

  // Captured item.
  logic [8:0]         it_ch;
  logic [15:0]        it_amp;
  logic signed [23:0] it_freq;

  logic [CW-1:0] clr_idx, tk_idx, a1;
  chan_rec_t     rd_q;
  logic          rd_en, wr_en;
  logic [CW-1:0] rd_addr, wr_addr;
  chan_rec_t     wr_rec;

  // Cosine build registers.
  logic [11:0] rk;
  logic [30:0] x;
  logic [31:0] x2;
  logic [30:0] t;
  logic [2:0]  kstep;
  logic [31:0] sub_q;
  logic [61:0] x_prod, x2_prod;
  logic [62:0] sub_prod;
  logic [45:0] fin_prod;
  logic [32:0] qv_t;

  // Load registers.
  logic signed [56:0] prod_q;
  logic signed [31:0] steps_q;
  logic               df_neg, da_neg_q;
  logic [32:0]        df_mag_q;
  logic signed [32:0] astep_q;

  // Tick pipeline.
  logic               v1, v2, v3, v4;
  logic [14:0]        qv_q;
  logic               neg2;
  logic [31:0]        amp2;
  logic signed [48:0] p3;
  logic signed [47:0] p4;
  logic signed [63:0] acc;

  logic               div_start, div_done;
  logic [32:0]        div_dividend, div_quo;
  logic [12:0]        div_divisor;

  logic [12:0]        hop;
  logic signed [56:0] hz_prod, sh17;
  logic signed [31:0] steps_sat;
  logic [16:0]        da_hi;
  logic [32:0]        da, da_mag, df, df_mag;
  logic               ld_silent;

  chan_rec_t          upd;
  logic [12:0]        tidx;
  logic [11:0]        qaddr;
  logic signed [15:0] cosv;
  logic signed [63:0] sh16;

  assign hop = (cfg.hop_length == 13'd0) ? 13'd1 : cfg.hop_length;

  assign hz_prod = 57'(it_freq) * $signed({25'd0, cfg.freq_scale});
  assign sh17    = prod_q >>> 17;
  always_comb begin
    if (sh17 > 57'sd2147483647)       steps_sat = 32'sh7FFF_FFFF;
    else if (sh17 < -57'sd2147483648) steps_sat = 32'sh8000_0000;
    else                              steps_sat = sh17[31:0];
  end

  assign da_hi  = {1'b0, it_amp} - {1'b0, rd_q.amp_target};
  assign da     = {da_hi, 16'd0};
  assign da_mag = da_hi[16] ? (~da + 33'd1) : da;
  assign df     = {steps_sat[31], steps_sat} - {rd_q.freq_target[31], rd_q.freq_target};
  assign df_mag = df[32] ? (~df + 33'd1) : df;

  assign ld_silent = ({1'b0, it_ch} >= cfg.active_channels) ||
                     (it_amp < cfg.amp_threshold);

  assign div_start    = cmd.rom_div_start | (cmd.ld_eval & ~ld_silent) | cmd.ld_da_take;
  assign div_dividend = cmd.rom_div_start ? {1'b0, sub_q} :
                        (cmd.ld_da_take ? df_mag_q : da_mag);
  assign div_divisor  = cmd.rom_div_start ? taylor_div(kstep) : hop;

  wtob_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Per-channel advance for one tick.
  always_comb begin
    upd       = rd_q;
    upd.phase = rd_q.phase + rd_q.freq_now;
    if (rd_q.ramp_left != 13'd0) begin
      upd.ramp_left = rd_q.ramp_left - 13'd1;
      if (rd_q.ramp_left == 13'd1) begin
        upd.amp_now  = {rd_q.amp_target, 16'd0};
        upd.freq_now = rd_q.freq_target;
      end else begin
        upd.amp_now  = rd_q.amp_now + rd_q.amp_step[31:0];
        upd.freq_now = rd_q.freq_now + rd_q.freq_step[31:0];
      end
    end
  end

  // Quarter-wave fold of the table index.
  assign tidx  = rd_q.phase[31:19];
  assign qaddr = tidx[11] ? (QROM_LAST - {1'b0, tidx[10:0]}) : {1'b0, tidx[10:0]};

  // Channel memory port selection.
  always_comb begin
    rd_en   = cmd.ld_read | cmd.tk_issue;
    rd_addr = cmd.tk_issue ? tk_idx : CW'(it_ch);
    wr_en   = 1'b0;
    wr_addr = CW'(it_ch);
    wr_rec  = rd_q;
    priority if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
      wr_rec  = '0;
    end else if (cmd.ld_eval && ld_silent) begin
      wr_en         = 1'b1;
      wr_rec.active = 1'b0;
    end else if (cmd.ld_df_take) begin
      wr_en              = 1'b1;
      wr_rec.amp_now     = {rd_q.amp_target, 16'd0};
      wr_rec.freq_now    = rd_q.freq_target;
      wr_rec.amp_step    = astep_q;
      wr_rec.freq_step   = df_neg ? -$signed(div_quo) : $signed(div_quo);
      wr_rec.amp_target  = it_amp;
      wr_rec.freq_target = steps_q;
      wr_rec.ramp_left   = hop;
      wr_rec.active      = 1'b1;
    end else if (v1 && rd_q.active) begin
      wr_en   = 1'b1;
      wr_addr = a1;
      wr_rec  = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) cmem[wr_addr] <= wr_rec;
    if (rd_en) rd_q <= cmem[rd_addr];
  end

  // Cosine table build arithmetic.
  assign x_prod   = {31'd0, rk, 19'd0} * {31'd0, HALF_PI_Q30};
  assign x2_prod  = {31'd0, x} * {31'd0, x};
  assign sub_prod = {31'd0, x2} * {32'd0, t};
  assign fin_prod = {15'd0, t} * 46'd32767 + 46'h2000_0000;
  assign qv_t     = {2'b00, Q30_ONE} - div_quo;

  always_ff @(posedge clk) begin
    if (cmd.rom_x)   x <= x_prod[60:30];
    if (cmd.rom_x2) begin
      x2    <= x2_prod[61:30];
      t     <= Q30_ONE;
      kstep <= 3'd7;
    end
    if (cmd.rom_mul) sub_q <= sub_prod[61:30];
    if (cmd.rom_div_take) begin
      t     <= (div_quo > {2'b00, Q30_ONE}) ? 31'd0 : qv_t[30:0];
      kstep <= kstep - 3'd1;
    end
    if (cmd.rom_fin) qrom[rk] <= fin_prod[44:30];
    if (v1)          qv_q <= qrom[qaddr];
  end

  // Control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      rk      <= '0;
      tk_idx  <= '0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_idx <= clr_idx + CW'(1);
      if (cmd.rom_fin)  rk <= rk + 12'd1;
      if (cmd.tk_start) tk_idx <= '0;
      else if (cmd.tk_issue) tk_idx <= tk_idx + CW'(1);
      v1 <= cmd.tk_issue;
      v2 <= v1 & rd_q.active;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Item capture and load arithmetic.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      it_ch   <= in_channel;
      it_amp  <= in_amplitude;
      it_freq <= in_frequency;
    end
    if (cmd.ld_read) prod_q <= hz_prod;
    if (cmd.ld_eval) begin
      steps_q  <= steps_sat;
      df_neg   <= df[32];
      df_mag_q <= df_mag;
      da_neg_q <= da_hi[16];
    end
    if (cmd.ld_da_take) astep_q <= da_neg_q ? -$signed(div_quo) : $signed(div_quo);
  end

  // Tick pipeline: table read, amplitude product, gain product, sum.
  assign cosv = neg2 ? -$signed({1'b0, qv_q}) : $signed({1'b0, qv_q});

  always_ff @(posedge clk) begin
    // The record read this cycle is written back in the next cycle.
    if (cmd.tk_issue) a1 <= tk_idx;
    if (v1) begin
      neg2 <= tidx[12] ^ tidx[11];
      amp2 <= rd_q.amp_now;
    end
    p3 <= $signed({1'b0, amp2}) * 49'(cosv);
    p4 <= 48'($signed(p3[48:15])) * $signed({35'd0, cfg.table_gain});
    if (cmd.tk_start) acc <= '0;
    else if (v4)      acc <= acc + 64'(p4);
  end

  assign sh16 = acc >>> 16;
  always_comb begin
    if (sh16 > 64'sd2147483647)       sample = 32'h7FFF_FFFF;
    else if (sh16 < -64'sd2147483648) sample = 32'h8000_0000;
    else                              sample = sh16[31:0];
  end

  always_comb begin
    stat            = '0;
    stat.clr_last   = (clr_idx == LAST_CH);
    stat.rom_last   = (rk == QROM_LAST);
    stat.k_last     = (kstep == 3'd1);
    stat.div_done   = div_done;
    stat.ld_skip    = (32'(it_ch) >= 32'(CHANNELS));
    stat.ld_silent  = ld_silent;
    stat.chan_last  = (tk_idx == LAST_CH);
    stat.pipe_empty = !(v1 | v2 | v3 | v4);
  end

endmodule

/* hdl/wavetable_oscillator_bank_unit.sv */
// Additive oscillator bank. A load word runs two divisions by the hop length, or none
// when the channel goes silent; a tick word walks the channel memory read port one
// channel per cycle, then drains its pipeline and waits for the output register to be
// taken. One word is in work at a time.
// Reset is synchronous: a clearing pass writes every channel record, then the
// quarter-wave cosine table is built; no input before.
module wavetable_oscillator_bank_unit import wtob_pkg::*; #(
  parameter int CHANNELS = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // channel[8:0], amplitude[24:9], frequency[48:25], zero
  input  logic [0:0]  s_tuser,   // mode: 0 load a channel, 1 produce a sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // sample[31:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t        cfg;
  cmd_t        cmd;
  stat_t       stat;
  logic [31:0] sample;
  logic        out_free;

  // Configuration registers are always writable; indexes past the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.amp_threshold   <= 16'd0;
      cfg.freq_scale      <= 32'd49807360;
      cfg.active_channels <= 10'd512;
      cfg.hop_length      <= 13'd128;
      cfg.table_gain      <= 13'd512;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_AMP_THRESHOLD:   cfg.amp_threshold   <= cfg_data[15:0];
        CFG_FREQ_SCALE:      cfg.freq_scale      <= cfg_data;
        CFG_ACTIVE_CHANNELS: cfg.active_channels <= cfg_data[9:0];
        CFG_HOP_LENGTH:      cfg.hop_length      <= cfg_data[12:0];
        CFG_TABLE_GAIN:      cfg.table_gain      <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // The output register frees up in the same cycle its word is taken.
  assign out_free = !m_tvalid || m_tready;

  wtob_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_mode  (s_tuser[0]),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  wtob_dp #(.CHANNELS(CHANNELS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg          (cfg),
    .in_channel   (s_tdata[8:0]),
    .in_amplitude (s_tdata[24:9]),
    .in_frequency (s_tdata[48:25]),
    .stat         (stat),
    .sample       (sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) m_tdata <= sample;
  end

  // A tick word keeps the block busy for at least the next cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser[0]) |=> !s_tready)
    else $error("block ready right after accepting a tick word");

  // A new sample appears only from the output stage, never while accepting input.
  a_out_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("sample produced while the block was idle");

  // Clearing, load reads, tick issues and table writes are never commanded together.
  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_step, cmd.ld_read, cmd.tk_issue, cmd.rom_fin}))
    else $error("conflicting datapath commands");

endmodule

/* test/tb_wavetable_oscillator_bank_unit.sv */
// Self-checking testbench for wavetable_oscillator_bank_unit.
// Depends on wtob_pkg for the register indexes; predicts every output sample with a
// scoreboard class that models the oscillator bank, its cosine table and its registers.
module tb_wavetable_oscillator_bank_unit;
  import wtob_pkg::*;

  localparam int NUM_CH     = 512;
  localparam int TAB_LEN    = 8192;
  localparam int WATCH_MAX  = 3000000;  // covers the cosine table build after reset
  localparam int SETTLE_CYC = 600;      // a tick walks all channels within this pause
  localparam bit MODE_LOAD  = 1'b0;
  localparam bit MODE_TICK  = 1'b1;

  // Scoreboard: holds its own copy of the bank state and the registers, and a queue
  // of samples that the ticks accepted so far are expected to produce.
  class osc_bank_scoreboard;
    shortint        cos_tab[TAB_LEN];
    longint         phase[NUM_CH];
    longint         amp_now[NUM_CH];
    longint         amp_step[NUM_CH];
    longint         freq_now[NUM_CH];
    longint         freq_step[NUM_CH];
    int unsigned    amp_tgt[NUM_CH];
    int             freq_tgt[NUM_CH];
    bit             live[NUM_CH];
    int unsigned    ramp_left[NUM_CH];
    bit [15:0]      amp_threshold;
    bit [31:0]      freq_scale;
    bit [9:0]       active_channels;
    bit [12:0]      hop_length;
    bit [12:0]      table_gain;
    bit [31:0]      expected_samples[$];
    int             errors;

    function new();
      for (int n = 0; n < TAB_LEN; n++) cos_tab[n] = cos_entry(n);
      for (int c = 0; c < NUM_CH; c++) begin
        phase[c] = 0; amp_now[c] = 0; amp_step[c] = 0; freq_now[c] = 0;
        freq_step[c] = 0; amp_tgt[c] = 0; freq_tgt[c] = 0; live[c] = 0;
        ramp_left[c] = 0;
      end
      amp_threshold = 0;
      freq_scale = 32'd49807360;
      active_channels = 10'd512;
      hop_length = 13'd128;
      table_gain = 13'd512;
      errors = 0;
    endfunction

    // Cosine of a quarter turn fraction r/2^30, Q30, by a degree-14 Taylor series.
    function longint unsigned quarter_cos(longint unsigned r);
      longint unsigned one, x, x2, t, d, sub;
      one = 64'd1 << 30;
      x = (r * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      t = one;
      for (int k = 7; k >= 1; k--) begin
        d = (2 * k - 1) * (2 * k);
        sub = ((x2 * t) >> 30) / d;
        t = (sub > one) ? 64'd0 : one - sub;
      end
      return t;
    endfunction

    function shortint cos_entry(int n);
      longint unsigned u, r, c;
      int unsigned quad;
      int v;
      u = (longint'(n) << 32) / TAB_LEN;
      quad = (u >> 30) & 3;
      r = u & ((64'd1 << 30) - 1);
      c = (quad == 0 || quad == 2) ? quarter_cos(r) : quarter_cos((64'd1 << 30) - r);
      v = int'((c * 64'd32767 + (64'd1 << 29)) >> 30);
      if (quad == 1 || quad == 2) v = -v;
      return shortint'(v);
    endfunction

    function void set_reg(logic [2:0] idx, bit [31:0] val);
      case (idx)
        CFG_AMP_THRESHOLD:   amp_threshold = val[15:0];
        CFG_FREQ_SCALE:      freq_scale = val;
        CFG_ACTIVE_CHANNELS: active_channels = val[9:0];
        CFG_HOP_LENGTH:      hop_length = val[12:0];
        CFG_TABLE_GAIN:      table_gain = val[12:0];
        default: ;
      endcase
    endfunction

    function void load_channel(int ch, bit [15:0] amp, bit signed [23:0] hz);
      longint hop, steps, old_a, old_f;
      hop = (hop_length == 0) ? 1 : longint'(hop_length);
      if (ch >= active_channels || amp < amp_threshold) begin
        live[ch] = 0;
        return;
      end
      steps = (longint'(hz) * longint'({32'b0, freq_scale})) >>> 17;
      if (steps > 64'sd2147483647) steps = 64'sd2147483647;
      if (steps < -64'sd2147483648) steps = -64'sd2147483648;
      old_a = longint'(amp_tgt[ch]) << 16;
      old_f = longint'(freq_tgt[ch]);
      amp_now[ch] = old_a;
      freq_now[ch] = old_f;
      amp_step[ch] = ((longint'(amp) << 16) - old_a) / hop;
      freq_step[ch] = (steps - old_f) / hop;
      amp_tgt[ch] = amp;
      freq_tgt[ch] = int'(steps);
      ramp_left[ch] = int'(hop);
      live[ch] = 1;
    endfunction

    function bit [31:0] tick_bank();
      longint span, acc, p, s;
      int idx;
      span = longint'(TAB_LEN) << 19;
      acc = 0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (!live[ch]) continue;
        idx = int'(phase[ch] >> 19);
        if (idx >= TAB_LEN) idx = 0;
        acc += ((amp_now[ch] * longint'(cos_tab[idx])) >>> 15) * longint'(table_gain);
        p = (phase[ch] + freq_now[ch]) % span;
        if (p < 0) p += span;
        phase[ch] = p;
        if (ramp_left[ch] > 0) begin
          ramp_left[ch]--;
          if (ramp_left[ch] == 0) begin
            amp_now[ch] = longint'(amp_tgt[ch]) << 16;
            freq_now[ch] = longint'(freq_tgt[ch]);
          end else begin
            amp_now[ch] += amp_step[ch];
            freq_now[ch] += freq_step[ch];
          end
        end
      end
      s = acc >>> 16;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s[31:0];
    endfunction

    // An accepted input word: loads update the model, ticks queue one sample.
    function void note_word(bit mode, bit [8:0] ch, bit [15:0] amp, bit [23:0] hz);
      if (mode == MODE_LOAD) load_channel(ch, amp, hz);
      else expected_samples.push_back(tick_bank());
    endfunction

    function void check_sample(bit [31:0] got);
      bit [31:0] want;
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none, actual %0d", $time,
                 $signed(got));
        errors++;
        return;
      end
      want = expected_samples.pop_front();
      if (want !== got) begin
        $display("%0t: sample mismatch, expected %0d, actual %0d", $time,
                 $signed(want), $signed(got));
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  osc_bank_scoreboard bank_sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  wavetable_oscillator_bank_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Result side: every sample word accepted at an edge is checked against the oldest
  // prediction, then the ready line is redrawn for the next cycle.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) bank_sb.check_sample(m_tdata);
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: any cycle in which no word moves on any channel counts toward the limit.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_MAX) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one input word, with random idle cycles in front of it. The valid line stays
  // high afterwards so back-to-back words need no extra assignment.
  task automatic send_word(bit mode, bit [8:0] ch, bit [15:0] amp, bit [23:0] hz);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {7'b0, hz, amp, ch};
    do @(posedge clk); while (!s_tready);
    bank_sb.note_word(mode, ch, amp, hz);
  endtask

  // Holds the sender off until every predicted sample has come back.
  task automatic drain_bank();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (bank_sb.expected_samples.size() != 0) @(posedge clk);
  endtask

  // Writes one register; the caller lowers cfg_valid after its last write.
  task automatic write_reg(logic [2:0] idx, bit [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    bank_sb.set_reg(idx, val);
  endtask

  // Full register set, written only once the bank is idle. Loads give no result, so a
  // settling pause covers one that may still be in work.
  task automatic set_bank(bit [15:0] thr, bit [31:0] scale, bit [9:0] act,
                          bit [12:0] hop, bit [12:0] gain);
    drain_bank();
    repeat (SETTLE_CYC) @(posedge clk);
    write_reg(CFG_AMP_THRESHOLD, thr);
    write_reg(CFG_FREQ_SCALE, scale);
    write_reg(CFG_ACTIVE_CHANNELS, act);
    write_reg(CFG_HOP_LENGTH, hop);
    write_reg(CFG_TABLE_GAIN, gain);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_words(int count);
    bit [8:0]  ch;
    bit [15:0] amp;
    bit [23:0] hz;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 199) == 0) drain_bank();
      if ($urandom_range(0, 99) < 40) begin
        send_word(MODE_TICK, 9'($urandom), 16'($urandom), 24'($urandom));
      end else begin
        ch = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 15));
        case ($urandom_range(0, 7))
          0:       amp = 16'hFFFF;
          1:       amp = 16'h0000;
          default: amp = 16'($urandom);
        endcase
        // Mix audible pitches with the full signed range of the field.
        hz = ($urandom_range(0, 1) == 0) ? 24'($urandom) : 24'($urandom_range(0, 65535));
        send_word(MODE_LOAD, ch, amp, hz);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet_cycles = 0;
    send_idle_pct = 9;
    recv_idle_pct = 74;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: field extremes, a silent channel past the active count, one below
    // the threshold, and a short hop so that ramp ends are reached.
    set_bank(16'd100, 32'd49807360, 10'd511, 13'd3, 13'd4096);
    send_word(MODE_LOAD, 9'd0, 16'hFFFF, 24'h7FFFFF);
    send_word(MODE_LOAD, 9'd511, 16'd200, 24'h800000);
    send_word(MODE_LOAD, 9'd1, 16'd50, 24'd1000);
    send_word(MODE_LOAD, 9'd2, 16'd100, 24'd0);
    send_word(MODE_LOAD, 9'd3, 16'hFFFF, 24'(440 << 8));
    repeat (5) send_word(MODE_TICK, 9'd0, 16'd0, 24'd0);
    send_word(MODE_LOAD, 9'd0, 16'd0, 24'd0);
    send_word(MODE_LOAD, 9'd3, 16'd30000, 24'hFFFF00);
    repeat (4) send_word(MODE_TICK, 9'h1FF, 16'hFFFF, 24'hFFFFFF);

    // Random part in six register settings; sender and receiver idling change per pair.
    set_bank(16'd0, 32'hFFFF_FFFF, 10'd512, 13'd1, 13'd4096);
    random_words(195);
    set_bank(16'hFFFF, 32'd0, 10'd0, 13'd4096, 13'd1);
    random_words(150);
    send_idle_pct = 74;
    recv_idle_pct = 9;
    set_bank(16'($urandom_range(0, 8000)), 32'd49807360, 10'd1023, 13'd0, 13'd8191);
    random_words(200);
    set_bank(16'd1000, 32'($urandom), 10'd300, 13'd5, 13'd0);
    random_words(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_bank(16'($urandom_range(0, 30000)), 32'h1000_0000, 10'd511, 13'h1FFF, 13'd512);
    random_words(200);
    set_bank(16'd20000, 32'd49807360, 10'd512, 13'd3, 13'd2);
    random_words(250);

    drain_bank();
    repeat (SETTLE_CYC) @(posedge clk);
    if (bank_sb.errors == 0 && bank_sb.expected_samples.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* wavetable_oscillator_bank_unit.f */
hdl/wtob_pkg.sv
hdl/wtob_div.sv
hdl/wtob_ctrl.sv
hdl/wtob_dp.sv
hdl/wavetable_oscillator_bank_unit.sv
test/tb_wavetable_oscillator_bank_unit.sv
